// File: src/wft_pkg.sv
// shared types, sizes and helpers for the word frequency top-two block
// used by wft_table_ram users, wft_engine, wft_emit and the top level
package wft_pkg;

    localparam int TABLE_WORDS    = 32;
    localparam int MAX_WORD_CHARS = 14;
    localparam int COUNT_BITS     = 8;

    localparam int CHAR_W     = 8;
    localparam int SLOT_W     = $clog2(TABLE_WORDS);
    localparam int STORED_W   = SLOT_W + 1;
    localparam int LEN_W      = $clog2(MAX_WORD_CHARS + 1);
    localparam int WORD_W     = CHAR_W * MAX_WORD_CHARS;
    localparam int SLOT_OUT_W = 5;
    localparam int SHOW_W     = 8;

    localparam logic [CHAR_W-1:0]     SPACE_CHAR = 8'd32;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};

    typedef struct packed {
        logic [CHAR_W-1:0] text_char;
        logic              end_of_text;
    } t_in;

    typedef struct packed {
        logic                  rank;
        logic [SLOT_OUT_W-1:0] word_slot;
        logic [CHAR_W-1:0]     word_char;
        logic                  char_valid;
        logic [SHOW_W-1:0]     word_count;
        logic                  word_end;
        logic                  table_overflow;
        logic                  last;
    } t_out;

    // one row of the word table
    typedef struct packed {
        logic [WORD_W-1:0]     word;
        logic [LEN_W-1:0]      len;
        logic [COUNT_BITS-1:0] count;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        t_entry            wdata;
        logic              re;
        logic [SLOT_W-1:0] raddr;
    } t_ram_cmd;

    typedef struct packed {
        logic                  rank;
        logic [SLOT_W-1:0]     slot;
        logic [WORD_W-1:0]     word;
        logic [LEN_W-1:0]      len;
        logic [COUNT_BITS-1:0] count;
        logic                  empty;
        logic                  overflow;
        logic                  last;
    } t_emit_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_INSERT,
        S_RANK_START,
        S_RANK,
        S_EMIT_RD,
        S_EMIT_LOAD,
        S_EMIT_WAIT
    } t_state;

    function automatic logic [SHOW_W-1:0] show_count(input logic [COUNT_BITS-1:0] c);
        logic [31:0] t;
        t = 32'(c);
        if (t > 32'd255) begin
            return 8'hFF;
        end
        return t[SHOW_W-1:0];
    endfunction

    function automatic logic [SLOT_OUT_W-1:0] show_slot(input logic [SLOT_W-1:0] s);
        logic [31:0] t;
        t = 32'(s);
        return t[SLOT_OUT_W-1:0];
    endfunction

endpackage

// File: src/wft_table_ram.sv
// generic single-port-write, single-port-read synchronous ram
// registered read, read returns the old data on a same-address write
module wft_table_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/wft_emit.sv
// output stage: streams one stored word as character transfers
// depends on wft_pkg
module wft_emit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  wft_pkg::t_emit_req i_req,
    output logic              o_done,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output wft_pkg::t_out     o_out_data
);

    logic                                r_valid;
    logic                                n_valid;
    wft_pkg::t_emit_req                  r_req;
    wft_pkg::t_emit_req                  n_req;
    logic                                w_end;
    logic                                w_xfer;

    assign w_end  = r_req.empty || (r_req.len == wft_pkg::LEN_W'(1));
    assign w_xfer = r_valid && i_out_ready;
    assign o_done = w_xfer && w_end;

    always_comb begin
        n_valid = r_valid;
        n_req   = r_req;
        if (i_start) begin
            n_valid = 1'b1;
            n_req   = i_req;
        end else if (w_xfer) begin
            if (w_end) begin
                n_valid = 1'b0;
            end else begin
                // next character moves to the low byte
                n_req.word = r_req.word >> wft_pkg::CHAR_W;
                n_req.len  = r_req.len - wft_pkg::LEN_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_req <= n_req;
    end

    always_comb begin
        o_out_data.rank           = r_req.rank;
        o_out_data.word_slot      = wft_pkg::show_slot(r_req.slot);
        o_out_data.word_char      = r_req.empty ? '0 : r_req.word[wft_pkg::CHAR_W-1:0];
        o_out_data.char_valid     = !r_req.empty;
        o_out_data.word_count     = wft_pkg::show_count(r_req.count);
        o_out_data.word_end       = w_end;
        o_out_data.table_overflow = r_req.overflow;
        o_out_data.last           = r_req.last && w_end;
    end

    assign o_out_valid = r_valid;

endmodule

// File: src/wft_engine.sv
// control and datapath: word assembly, table search and update, top-two ranking
// depends on wft_pkg; drives the table ram and the output stage
module wft_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  wft_pkg::t_in       i_in_data,
    output wft_pkg::t_ram_cmd  o_ram_cmd,
    input  wft_pkg::t_entry    i_ram_rdata,
    output wft_pkg::t_emit_req o_emit_req,
    output logic               o_emit_start,
    input  logic               i_emit_done
);

    wft_pkg::t_state r_state, n_state;

    logic [wft_pkg::WORD_W-1:0]     r_cur_word, n_cur_word;
    logic [wft_pkg::LEN_W-1:0]      r_cur_len,  n_cur_len;
    logic                           r_eot,      n_eot;
    logic [wft_pkg::STORED_W-1:0]   r_stored,   n_stored;
    logic                           r_overflow, n_overflow;
    logic [wft_pkg::SLOT_W-1:0]     r_idx,      n_idx;
    logic [wft_pkg::SLOT_W-1:0]     r_first,    n_first;
    logic [wft_pkg::COUNT_BITS-1:0] r_c1,       n_c1;
    logic [wft_pkg::SLOT_W-1:0]     r_second,   n_second;
    logic [wft_pkg::COUNT_BITS-1:0] r_c2,       n_c2;
    logic                           r_have2,    n_have2;
    logic                           r_rank,     n_rank;

    logic                           w_accept;
    logic                           w_space;
    logic [wft_pkg::WORD_W-1:0]     w_app_word;
    logic [wft_pkg::LEN_W-1:0]      w_app_len;
    logic                           w_close;
    logic                           w_match;
    logic                           w_idx_last;
    logic                           w_full;
    logic [wft_pkg::SLOT_W-1:0]     w_emit_slot;
    wft_pkg::t_entry                w_bumped;
    wft_pkg::t_entry                w_new;

    assign w_accept   = i_in_valid && (r_state == wft_pkg::S_IDLE);
    assign w_space    = (i_in_data.text_char == wft_pkg::SPACE_CHAR);
    assign w_match    = (i_ram_rdata.len == r_cur_len) && (i_ram_rdata.word == r_cur_word);
    assign w_idx_last = ((wft_pkg::STORED_W'(r_idx) + wft_pkg::STORED_W'(1)) == r_stored);
    assign w_full     = (r_stored == wft_pkg::STORED_W'(wft_pkg::TABLE_WORDS));
    assign w_emit_slot = (r_rank && r_have2) ? r_second : r_first;

    // word after this byte; characters past the limit are dropped
    always_comb begin
        w_app_word = r_cur_word;
        w_app_len  = r_cur_len;
        if (!w_space && (r_cur_len < wft_pkg::LEN_W'(wft_pkg::MAX_WORD_CHARS))) begin
            w_app_word[{r_cur_len, 3'b000} +: wft_pkg::CHAR_W] = i_in_data.text_char;
            w_app_len = r_cur_len + wft_pkg::LEN_W'(1);
        end
    end

    assign w_close = (w_space || i_in_data.end_of_text) && (w_app_len != '0);

    always_comb begin
        w_bumped = i_ram_rdata;
        if (i_ram_rdata.count != wft_pkg::COUNT_MAX) begin
            w_bumped.count = i_ram_rdata.count + wft_pkg::COUNT_BITS'(1);
        end
        w_new.word  = r_cur_word;
        w_new.len   = r_cur_len;
        w_new.count = wft_pkg::COUNT_BITS'(1);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            wft_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (w_close) begin
                        n_state = (r_stored == '0) ? wft_pkg::S_INSERT : wft_pkg::S_SCAN;
                    end else if (i_in_data.end_of_text) begin
                        n_state = wft_pkg::S_RANK_START;
                    end
                end
            end
            wft_pkg::S_SCAN: begin
                if (w_match) begin
                    n_state = r_eot ? wft_pkg::S_RANK_START : wft_pkg::S_IDLE;
                end else if (w_idx_last) begin
                    n_state = wft_pkg::S_INSERT;
                end
            end
            wft_pkg::S_INSERT: begin
                n_state = r_eot ? wft_pkg::S_RANK_START : wft_pkg::S_IDLE;
            end
            wft_pkg::S_RANK_START: begin
                n_state = (r_stored == '0) ? wft_pkg::S_EMIT_RD : wft_pkg::S_RANK;
            end
            wft_pkg::S_RANK: begin
                if (w_idx_last) begin
                    n_state = wft_pkg::S_EMIT_RD;
                end
            end
            wft_pkg::S_EMIT_RD: begin
                n_state = wft_pkg::S_EMIT_LOAD;
            end
            wft_pkg::S_EMIT_LOAD: begin
                n_state = wft_pkg::S_EMIT_WAIT;
            end
            wft_pkg::S_EMIT_WAIT: begin
                if (i_emit_done) begin
                    n_state = r_rank ? wft_pkg::S_IDLE : wft_pkg::S_EMIT_RD;
                end
            end
            default: begin
                n_state = wft_pkg::S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready      = 1'b0;
        o_emit_start    = 1'b0;
        o_ram_cmd.we    = 1'b0;
        o_ram_cmd.waddr = r_idx;
        o_ram_cmd.wdata = w_bumped;
        o_ram_cmd.re    = 1'b0;
        o_ram_cmd.raddr = '0;
        case (r_state)
            wft_pkg::S_IDLE: begin
                // slot 0 is fetched ahead so the search starts at once
                o_in_ready   = 1'b1;
                o_ram_cmd.re = 1'b1;
            end
            wft_pkg::S_SCAN: begin
                o_ram_cmd.we    = w_match;
                o_ram_cmd.re    = 1'b1;
                o_ram_cmd.raddr = r_idx + wft_pkg::SLOT_W'(1);
            end
            wft_pkg::S_INSERT: begin
                o_ram_cmd.we    = !w_full;
                o_ram_cmd.waddr = r_stored[wft_pkg::SLOT_W-1:0];
                o_ram_cmd.wdata = w_new;
            end
            wft_pkg::S_RANK_START: begin
                o_ram_cmd.re = 1'b1;
            end
            wft_pkg::S_RANK: begin
                o_ram_cmd.re    = 1'b1;
                o_ram_cmd.raddr = r_idx + wft_pkg::SLOT_W'(1);
            end
            wft_pkg::S_EMIT_RD: begin
                o_ram_cmd.re    = 1'b1;
                o_ram_cmd.raddr = w_emit_slot;
            end
            wft_pkg::S_EMIT_LOAD: begin
                o_emit_start = 1'b1;
            end
            wft_pkg::S_EMIT_WAIT: begin
                o_emit_start = 1'b0;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_emit_req.rank     = r_rank;
        o_emit_req.slot     = w_emit_slot;
        o_emit_req.word     = i_ram_rdata.word;
        o_emit_req.len      = i_ram_rdata.len;
        o_emit_req.empty    = (r_stored == '0);
        o_emit_req.overflow = r_overflow;
        o_emit_req.last     = r_rank;
        if (r_rank) begin
            o_emit_req.count = r_have2 ? r_c2 : '0;
        end else begin
            o_emit_req.count = (r_stored == '0) ? '0 : r_c1;
        end
    end

    // datapath next values
    always_comb begin
        n_cur_word = r_cur_word;
        n_cur_len  = r_cur_len;
        n_eot      = r_eot;
        n_stored   = r_stored;
        n_overflow = r_overflow;
        n_idx      = r_idx;
        n_first    = r_first;
        n_c1       = r_c1;
        n_second   = r_second;
        n_c2       = r_c2;
        n_have2    = r_have2;
        n_rank     = r_rank;
        case (r_state)
            wft_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_cur_word = w_app_word;
                    n_cur_len  = w_app_len;
                    n_eot      = i_in_data.end_of_text;
                    n_idx      = '0;
                end
            end
            wft_pkg::S_SCAN: begin
                if (w_match) begin
                    n_cur_word = '0;
                    n_cur_len  = '0;
                end else if (!w_idx_last) begin
                    n_idx = r_idx + wft_pkg::SLOT_W'(1);
                end
            end
            wft_pkg::S_INSERT: begin
                if (w_full) begin
                    n_overflow = 1'b1;
                end else begin
                    n_stored = r_stored + wft_pkg::STORED_W'(1);
                end
                n_cur_word = '0;
                n_cur_len  = '0;
            end
            wft_pkg::S_RANK_START: begin
                n_idx   = '0;
                n_first = '0;
                n_have2 = 1'b0;
                n_rank  = 1'b0;
            end
            wft_pkg::S_RANK: begin
                // running top two, strict compares keep the lower slot on ties
                if (r_idx == '0) begin
                    n_first = '0;
                    n_c1    = i_ram_rdata.count;
                end else if (i_ram_rdata.count > r_c1) begin
                    n_second = r_first;
                    n_c2     = r_c1;
                    n_have2  = 1'b1;
                    n_first  = r_idx;
                    n_c1     = i_ram_rdata.count;
                end else if (!r_have2 || (i_ram_rdata.count > r_c2)) begin
                    n_second = r_idx;
                    n_c2     = i_ram_rdata.count;
                    n_have2  = 1'b1;
                end
                if (!w_idx_last) begin
                    n_idx = r_idx + wft_pkg::SLOT_W'(1);
                end
            end
            wft_pkg::S_EMIT_WAIT: begin
                if (i_emit_done) begin
                    if (r_rank) begin
                        n_rank     = 1'b0;
                        n_stored   = '0;
                        n_overflow = 1'b0;
                        n_eot      = 1'b0;
                    end else begin
                        n_rank = 1'b1;
                    end
                end
            end
            default: begin
                n_rank = r_rank;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= wft_pkg::S_IDLE;
            r_cur_word <= '0;
            r_cur_len  <= '0;
            r_eot      <= 1'b0;
            r_stored   <= '0;
            r_overflow <= 1'b0;
            r_rank     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cur_word <= n_cur_word;
            r_cur_len  <= n_cur_len;
            r_eot      <= n_eot;
            r_stored   <= n_stored;
            r_overflow <= n_overflow;
            r_rank     <= n_rank;
        end
        r_idx    <= n_idx;
        r_first  <= n_first;
        r_c1     <= n_c1;
        r_second <= n_second;
        r_c2     <= n_c2;
        r_have2  <= n_have2;
    end

endmodule

// File: src/word_frequency_top_two.sv
// Word frequency top two: takes text bytes, counts space-separated words in a
// 32-entry table held in one synchronous ram, and at end of text streams the
// most and second most frequent word one character per output transfer. A
// byte that closes a word starts a search that reads the stored words one slot
// per cycle and inserts the word when no slot matches. At end of text, ranking
// reads all stored words at one slot per cycle, then each reported word is read
// from the ram and loaded into the output stage before its characters go out.
// No new byte is taken until the whole report has gone out. Table contents need
// no clearing pass after reset or after a report.
// depends on wft_pkg, wft_table_ram, wft_emit and wft_engine
module word_frequency_top_two (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  wft_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output wft_pkg::t_out o_out_data
);

    wft_pkg::t_ram_cmd             w_ram_cmd;
    logic [wft_pkg::ENTRY_W-1:0]   w_ram_rdata;
    wft_pkg::t_emit_req            w_emit_req;
    logic                          w_emit_start;
    logic                          w_emit_done;

    wft_table_ram #(
        .WIDTH (wft_pkg::ENTRY_W),
        .DEPTH (wft_pkg::TABLE_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_cmd.we),
        .i_waddr (w_ram_cmd.waddr),
        .i_wdata (w_ram_cmd.wdata),
        .i_re    (w_ram_cmd.re),
        .i_raddr (w_ram_cmd.raddr),
        .o_rdata (w_ram_rdata)
    );

    wft_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .o_ram_cmd    (w_ram_cmd),
        .i_ram_rdata  (wft_pkg::t_entry'(w_ram_rdata)),
        .o_emit_req   (w_emit_req),
        .o_emit_start (w_emit_start),
        .i_emit_done  (w_emit_done)
    );

    wft_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_emit_start),
        .i_req       (w_emit_req),
        .o_done      (w_emit_done),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
